FILE: hdl/wma_pkg.sv
// ----------------------------------------------------------------------------
// wma_pkg
// Shared widths, register map and reset values for the moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package wma_pkg;

    // Item field widths
    localparam int SAMPLE_W = 32;
    localparam int N_W      = 7;    // window length / samples used
    localparam int SUM_W    = SAMPLE_W + N_W;

    // Default ring depth
    localparam int MAX_WINDOW_DEF = 64;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_WINDOW_LEN = 1'b0;   // register index (paddr[2])
    localparam logic [N_W-1:0] WINDOW_LEN_RST = 7'd5;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(SUM_W);

endpackage

`default_nettype wire

FILE: hdl/warmup_moving_average.sv
// ----------------------------------------------------------------------------
// warmup_moving_average
// Streaming simple moving average of signed Q16.16 samples with warm-up:
// mean of all samples so far until the window fills, then of the last
// window_len samples.
//
//   Channel   Dir  Handshake          Payload
//   input     in   i_valid / o_ready  i_sample, i_last_of_series
//   result    out  o_valid / i_ready  o_average, o_samples_used
//   config    in   APB (psel...)      window_len at byte address 0
//
// Each item passes in the back part through a pop, one ring read for each of
// the n - 1 older samples of its mean (single read port, registered read
// data), a start, a 39-step bit-serial divide with a finish, and a result
// load. The back part handles one item at a time.
// A two-entry queue lets the front accept items while the back part works,
// and the result register holds a result while the next item is summed;
// the back part waits in its load state while that result is not taken.
// Reset is synchronous; no clearing pass is needed, no ring entry is summed
// before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module warmup_moving_average #(
    parameter int MAX_WINDOW = wma_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Sample items
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [wma_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_last_of_series,
    // Result items
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [wma_pkg::SAMPLE_W-1:0]      o_average,
    output logic [wma_pkg::N_W-1:0]                  o_samples_used,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wma_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [wma_pkg::DATA_W-1:0]          pwdata,
    output logic [wma_pkg::DATA_W-1:0]               prdata,
    output logic                                     pready
);

    localparam int SW    = $clog2(MAX_WINDOW);
    localparam int SMP_W = wma_pkg::SAMPLE_W;
    localparam int N_W   = wma_pkg::N_W;
    localparam int Q_W   = SMP_W + SW + N_W;

    logic [N_W-1:0]   r_window_len;
    logic             reg_hit;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [SMP_W-1:0] f_sample;
    logic [SW-1:0]    f_slot;
    logic [N_W-1:0]   f_n;
    logic [Q_W-1:0]   q_data;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == wma_pkg::REG_WINDOW_LEN) && (paddr[1:0] == 2'b00);
    assign prdata  = reg_hit ? wma_pkg::DATA_W'(r_window_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= wma_pkg::WINDOW_LEN_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == wma_pkg::REG_WINDOW_LEN)) begin
            r_window_len <= pwdata[N_W-1:0];
        end
    end

    // Front: slot and count tagging
    wma_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_window_len     (r_window_len),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .i_last_of_series (i_last_of_series),
        .o_push           (push),
        .i_full           (q_full),
        .o_sample         (f_sample),
        .o_slot           (f_slot),
        .o_n              (f_n)
    );

    // Queue between front and back
    wma_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_sample, f_slot, f_n}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back: ring, sum, divide, result register
    wma_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job_sample   (q_data[Q_W-1 -: SMP_W]),
        .i_job_slot     (q_data[N_W +: SW]),
        .i_job_n        (q_data[N_W-1:0]),
        .o_job_pop      (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_average      (o_average),
        .o_samples_used (o_samples_used)
    );

endmodule

`default_nettype wire

FILE: hdl/wma_ram.sv
// ----------------------------------------------------------------------------
// wma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/wma_front.sv
// ----------------------------------------------------------------------------
// wma_front
// Accepts sample items, tracks ring slot and fill count, and tags each item
// with its ring slot and the number of samples its mean covers.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_front #(
    parameter int MAX_WINDOW = wma_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [wma_pkg::N_W-1:0]           i_window_len,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [wma_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                              i_last_of_series,
    output logic                                   o_push,
    input  wire logic                              i_full,
    output logic [wma_pkg::SAMPLE_W-1:0]           o_sample,
    output logic [$clog2(MAX_WINDOW)-1:0]          o_slot,
    output logic [wma_pkg::N_W-1:0]                o_n
);

    localparam int SW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [SW-1:0]           r_slot;
    logic [CW-1:0]           r_fill;
    logic [CW-1:0]           n_fill;
    logic [SW-1:0]           n_slot;
    logic [wma_pkg::N_W-1:0] w_eff;

    assign o_ready  = !i_full;
    assign o_push   = i_valid && !i_full;
    assign o_sample = i_sample;
    assign o_slot   = r_slot;

    // Effective window: zero acts as one, clamp to ring depth
    always_comb begin
        w_eff = i_window_len;
        if (i_window_len == '0) begin
            w_eff = wma_pkg::N_W'(1);
        end else if (32'(i_window_len) > 32'(MAX_WINDOW)) begin
            w_eff = wma_pkg::N_W'(MAX_WINDOW);
        end
    end

    // Fill count after this item, saturating; next ring slot with wrap
    always_comb begin
        n_fill = r_fill;
        if (32'(r_fill) < 32'(MAX_WINDOW)) begin
            n_fill = r_fill + CW'(1);
        end
        n_slot = (32'(r_slot) == MAX_WINDOW - 1) ? '0 : r_slot + SW'(1);
        o_n = w_eff;
        if (32'(n_fill) < 32'(w_eff)) begin
            o_n = wma_pkg::N_W'(n_fill);
        end
    end

    // Series state; a marked item clears it after its own use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
        end else if (o_push) begin
            if (i_last_of_series) begin
                r_slot <= '0;
                r_fill <= '0;
            end else begin
                r_slot <= n_slot;
                r_fill <= n_fill;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wma_queue.sv
// ----------------------------------------------------------------------------
// wma_queue
// Two-entry FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wma_div.sv
// ----------------------------------------------------------------------------
// wma_div
// Restoring divider, one quotient bit per cycle: signed sum by a small
// unsigned count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [wma_pkg::SUM_W-1:0]    i_dividend,
    input  wire logic [wma_pkg::N_W-1:0]             i_divisor,
    output logic                                     o_done,
    output logic [wma_pkg::SAMPLE_W-1:0]             o_quotient
);

    localparam int SUM_W = wma_pkg::SUM_W;
    localparam int N_W   = wma_pkg::N_W;
    localparam int CNT_W = wma_pkg::DIV_CNT_W;

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [N_W-1:0]       r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [N_W-1:0]       r_div;
    logic                 r_neg;
    logic [SUM_W-1:0]     mag;
    logic [N_W:0]         trial;
    logic [N_W:0]         diff;
    logic                 ge;

    assign mag   = i_dividend[SUM_W-1] ? (-i_dividend) : i_dividend;
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    // Apply sign; magnitude of the quotient always fits the output width
    assign o_quotient = r_neg ? (-r_quo[wma_pkg::SAMPLE_W-1:0])
                              : r_quo[wma_pkg::SAMPLE_W-1:0];

    // Data path
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wma_back.sv
// ----------------------------------------------------------------------------
// wma_back
// Writes each sample into the ring, sums the window by walking back through
// the ring one entry a cycle, divides, and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module wma_back #(
    parameter int MAX_WINDOW = wma_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_job_valid,
    input  wire logic [wma_pkg::SAMPLE_W-1:0]      i_job_sample,
    input  wire logic [$clog2(MAX_WINDOW)-1:0]     i_job_slot,
    input  wire logic [wma_pkg::N_W-1:0]           i_job_n,
    output logic                                   o_job_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [wma_pkg::SAMPLE_W-1:0]    o_average,
    output logic [wma_pkg::N_W-1:0]                o_samples_used
);

    localparam int SW    = $clog2(MAX_WINDOW);
    localparam int SUM_W = wma_pkg::SUM_W;
    localparam int SMP_W = wma_pkg::SAMPLE_W;
    localparam int N_W   = wma_pkg::N_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_back_state;

    t_back_state              r_state;
    t_back_state              n_state;
    logic signed [SUM_W-1:0]  r_sum;
    logic [N_W-1:0]           r_left;
    logic [N_W-1:0]           r_n;
    logic [SW-1:0]            r_addr;
    logic                     r_pend;
    logic [SMP_W-1:0]         r_q;
    logic [SMP_W-1:0]         rd_data;
    logic                     div_start;
    logic                     div_done;
    logic [SMP_W-1:0]         div_q;
    logic                     out_load;

    function automatic logic [SW-1:0] prev_slot(input logic [SW-1:0] a);
        prev_slot = (a == '0) ? SW'(MAX_WINDOW - 1) : a - SW'(1);
    endfunction

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign div_start = (r_state == S_SUM) && (r_left == '0) && !r_pend;
    assign out_load  = (r_state == S_OUT) && (!o_valid || i_ready);

    // Ring of recent samples
    wma_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (o_job_pop),
        .i_waddr (i_job_slot),
        .i_wdata (i_job_sample),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // Mean = sum / count
    wma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) n_state = S_SUM;
            end
            S_SUM: begin
                if (div_start) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Window walk and accumulation
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_sum  <= SUM_W'(signed'(i_job_sample));
            r_left <= i_job_n - N_W'(1);
            r_n    <= i_job_n;
            r_addr <= prev_slot(i_job_slot);
        end else if (r_state == S_SUM) begin
            if (r_left != '0) begin
                r_left <= r_left - N_W'(1);
                r_addr <= prev_slot(r_addr);
            end
            if (r_pend) begin
                r_sum <= r_sum + SUM_W'(signed'(rd_data));
            end
        end
        if (div_done) begin
            r_q <= div_q;
        end
        if (out_load) begin
            o_average      <= r_q;
            o_samples_used <= r_n;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_SUM) && (r_left != '0);
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
